// ===== src/parallel_link_rx_deframer_macros.svh =====
// Assertion helpers for the deframer. Both expect clk and rst_n in scope.
`ifndef PARALLEL_LINK_RX_DEFRAMER_MACROS_SVH
`define PARALLEL_LINK_RX_DEFRAMER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PLDF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer check failed");

// Consequent must hold in the cycle after the antecedent.
`define PLDF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

// ===== src/pldf_pkg.sv =====
package pldf_pkg;

  localparam int HEADER_BYTES     = 14;
  localparam int ADDRESS_BYTES    = 6;
  localparam int COMPRESSED_BYTES = 4;
  localparam int HDR_IDX_W        = 4;
  localparam int CFG_INDEX_W      = 2;
  localparam int CFG_DATA_W       = 40;

  localparam logic [7:0]  TYPE_FULL        = 8'hfd;
  localparam logic [7:0]  TYPE_COMPRESSED  = 8'hfc;
  localparam logic [15:0] MIN_LENGTH       = 16'd14;
  localparam logic [15:0] MAX_LENGTH_RESET = 16'd1600;

  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LENGTH     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_STATION_PREFIX = 2'd1;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_CKSUM    = 3'd1,
    ST_BAD_LEN  = 3'd2,
    ST_BAD_TYPE = 3'd3,
    ST_TIMEOUT  = 3'd4
  } status_t;

  // One access to the header store: a write port and a read port.
  typedef struct packed {
    logic                 we;
    logic [HDR_IDX_W-1:0] waddr;
    logic [7:0]           wdata;
    logic                 re;
    logic [HDR_IDX_W-1:0] raddr;
  } mem_req_t;

  // True for header positions that a compressed header takes from the prefix.
  function automatic logic is_prefix_pos(input logic [HDR_IDX_W-1:0] pos);
    return (pos != HDR_IDX_W'(ADDRESS_BYTES - 1)) && (pos < HDR_IDX_W'(2 * ADDRESS_BYTES - 1));
  endfunction

  // Prefix byte for a destination or source address position.
  function automatic logic [7:0] prefix_byte(input logic [CFG_DATA_W-1:0] prefix,
                                             input logic [HDR_IDX_W-1:0] pos);
    logic [HDR_IDX_W-1:0] k;
    logic [7:0]           b;
    k = (pos < HDR_IDX_W'(ADDRESS_BYTES)) ? pos : HDR_IDX_W'(pos - HDR_IDX_W'(ADDRESS_BYTES));
    case (k)
      4'd0:    b = prefix[39:32];
      4'd1:    b = prefix[31:24];
      4'd2:    b = prefix[23:16];
      4'd3:    b = prefix[15:8];
      4'd4:    b = prefix[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== src/pldf_hdr_mem.sv =====
module pldf_hdr_mem
  import pldf_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output logic [7:0] rd_data
);

  logic [7:0] mem [HEADER_BYTES];
  logic [7:0] rd_data_r;

  // Read data stays put until the next read is issued.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data_r <= mem[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/pldf_parser.sv =====
module pldf_parser
  import pldf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            rx_byte,
  input  logic                  timed_out,
  input  logic [15:0]           max_length,
  input  logic [CFG_DATA_W-1:0] station_prefix,
  output mem_req_t              mem_req,
  input  logic [7:0]            mem_rd_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_byte,
  output logic                  is_data,
  output logic                  last,
  output status_t               status,
  output logic [15:0]           frame_length
);

  typedef enum logic [2:0] {
    S_IDLE, S_LEN_HI, S_LEN_LO, S_HEADER, S_BURST, S_DATA, S_CHECK
  } state_t;

  state_t               state_r, state_nxt;
  logic                 comp_r, comp_nxt;
  logic [15:0]          len_r, len_nxt;
  logic [15:0]          rem_r, rem_nxt;
  logic [7:0]           sum_r, sum_nxt;
  logic [HDR_IDX_W-1:0] hidx_r, hidx_nxt;
  logic [HDR_IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic                 rd_pend_r, rd_pend_nxt;

  logic                 ovalid_r, ovalid_nxt;
  logic [7:0]           obyte_r, obyte_nxt;
  logic                 odata_r, odata_nxt;
  logic                 olast_r, olast_nxt;
  status_t              ostat_r, ostat_nxt;
  logic [15:0]          olen_r, olen_nxt;

  logic                 emit_ok, acc, go_idle, consume;
  logic [HDR_IDX_W-1:0] hdr_last, wpos;
  logic [7:0]           hdr_byte;

  assign emit_ok  = !ovalid_r || out_ready;
  assign in_ready = (state_r != S_BURST) && emit_ok;
  assign acc      = in_valid && in_ready;
  assign hdr_last = comp_r ? HDR_IDX_W'(COMPRESSED_BYTES - 1) : HDR_IDX_W'(HEADER_BYTES - 1);
  assign consume  = (state_r == S_BURST) && rd_pend_r && emit_ok;
  assign hdr_byte = (comp_r && is_prefix_pos(hidx_r)) ? prefix_byte(station_prefix, hidx_r)
                                                      : mem_rd_data;

  always_comb begin
    priority if (!comp_r) begin
      wpos = hidx_r;
    end else if (hidx_r == '0) begin
      wpos = HDR_IDX_W'(ADDRESS_BYTES - 1);
    end else if (hidx_r == HDR_IDX_W'(1)) begin
      wpos = HDR_IDX_W'(2 * ADDRESS_BYTES - 1);
    end else begin
      wpos = HDR_IDX_W'(2 * ADDRESS_BYTES) + {{(HDR_IDX_W-1){1'b0}}, hidx_r[0]};
    end
  end

  always_comb begin
    state_nxt   = state_r;
    comp_nxt    = comp_r;
    len_nxt     = len_r;
    rem_nxt     = rem_r;
    sum_nxt     = sum_r;
    hidx_nxt    = hidx_r;
    rd_idx_nxt  = rd_idx_r;
    rd_pend_nxt = rd_pend_r;
    ovalid_nxt  = ovalid_r && !out_ready;
    obyte_nxt   = obyte_r;
    odata_nxt   = odata_r;
    olast_nxt   = olast_r;
    ostat_nxt   = ostat_r;
    olen_nxt    = olen_r;
    mem_req     = '0;
    go_idle     = 1'b0;

    if (acc) begin
      if (timed_out) begin
        ovalid_nxt = 1'b1; obyte_nxt = 8'h00; odata_nxt = 1'b0; olast_nxt = 1'b1;
        ostat_nxt  = ST_TIMEOUT; olen_nxt = len_r;
        go_idle    = 1'b1;
      end else begin
        unique case (state_r)
          S_IDLE: begin
            if (rx_byte == TYPE_FULL || rx_byte == TYPE_COMPRESSED) begin
              comp_nxt  = (rx_byte == TYPE_COMPRESSED);
              state_nxt = S_LEN_HI;
            end else begin
              ovalid_nxt = 1'b1; obyte_nxt = 8'h00; odata_nxt = 1'b0; olast_nxt = 1'b1;
              ostat_nxt  = ST_BAD_TYPE; olen_nxt = len_r;
              go_idle    = 1'b1;
            end
          end
          S_LEN_HI: begin
            len_nxt   = {rx_byte, 8'h00};
            state_nxt = S_LEN_LO;
          end
          S_LEN_LO: begin
            len_nxt   = {len_r[15:8], rx_byte};
            hidx_nxt  = '0;
            state_nxt = S_HEADER;
          end
          S_HEADER: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = wpos;
            mem_req.wdata = rx_byte;
            hidx_nxt      = hidx_r + HDR_IDX_W'(1);
            if (hidx_r == hdr_last) begin
              if (len_r < MIN_LENGTH || len_r > max_length) begin
                ovalid_nxt = 1'b1; obyte_nxt = 8'h00; odata_nxt = 1'b0; olast_nxt = 1'b1;
                ostat_nxt  = ST_BAD_LEN; olen_nxt = len_r;
                go_idle    = 1'b1;
              end else begin
                hidx_nxt    = '0;
                rd_idx_nxt  = '0;
                rd_pend_nxt = 1'b0;
                sum_nxt     = 8'h00;
                rem_nxt     = len_r - MIN_LENGTH;
                state_nxt   = S_BURST;
              end
            end
          end
          S_DATA: begin
            ovalid_nxt = 1'b1; obyte_nxt = rx_byte; odata_nxt = 1'b1; olast_nxt = 1'b0;
            ostat_nxt  = ST_OK; olen_nxt = len_r;
            sum_nxt    = sum_r + rx_byte;
            rem_nxt    = rem_r - 16'd1;
            if (rem_r == 16'd1) begin
              state_nxt = S_CHECK;
            end
          end
          S_CHECK: begin
            ovalid_nxt = 1'b1; obyte_nxt = 8'h00; odata_nxt = 1'b0; olast_nxt = 1'b1;
            ostat_nxt  = (sum_r == rx_byte) ? ST_OK : ST_CKSUM;
            olen_nxt   = len_r;
            go_idle    = 1'b1;
          end
          default: begin
          end
        endcase
      end
    end

    // Header replay: one read in flight; with a read pending, reads stop while the output holds.
    if (state_r == S_BURST) begin
      if (consume) begin
        ovalid_nxt = 1'b1; obyte_nxt = hdr_byte; odata_nxt = 1'b1; olast_nxt = 1'b0;
        ostat_nxt  = ST_OK; olen_nxt = len_r;
        sum_nxt    = sum_r + hdr_byte;
        hidx_nxt   = hidx_r + HDR_IDX_W'(1);
        if (hidx_r == HDR_IDX_W'(HEADER_BYTES - 1)) begin
          hidx_nxt  = '0;
          state_nxt = (rem_r != 16'd0) ? S_DATA : S_CHECK;
        end
      end
      if ((!rd_pend_r || consume) && rd_idx_r != HDR_IDX_W'(HEADER_BYTES)) begin
        mem_req.re    = 1'b1;
        mem_req.raddr = rd_idx_r;
        rd_idx_nxt    = rd_idx_r + HDR_IDX_W'(1);
        rd_pend_nxt   = 1'b1;
      end else if (consume) begin
        rd_pend_nxt = 1'b0;
      end
    end

    if (go_idle) begin
      state_nxt = S_IDLE;
      comp_nxt  = 1'b0;
      len_nxt   = 16'd0;
      rem_nxt   = 16'd0;
      sum_nxt   = 8'h00;
      hidx_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      comp_r    <= 1'b0;
      len_r     <= 16'd0;
      rem_r     <= 16'd0;
      sum_r     <= 8'h00;
      hidx_r    <= '0;
      rd_idx_r  <= '0;
      rd_pend_r <= 1'b0;
      ovalid_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      comp_r    <= comp_nxt;
      len_r     <= len_nxt;
      rem_r     <= rem_nxt;
      sum_r     <= sum_nxt;
      hidx_r    <= hidx_nxt;
      rd_idx_r  <= rd_idx_nxt;
      rd_pend_r <= rd_pend_nxt;
      ovalid_r  <= ovalid_nxt;
    end
    obyte_r <= obyte_nxt;
    odata_r <= odata_nxt;
    olast_r <= olast_nxt;
    ostat_r <= ostat_nxt;
    olen_r  <= olen_nxt;
  end

  assign out_valid    = ovalid_r;
  assign out_byte     = obyte_r;
  assign is_data      = odata_r;
  assign last         = olast_r;
  assign status       = ostat_r;
  assign frame_length = olen_r;

endmodule

// ===== src/parallel_link_rx_deframer.sv =====
// A data, status or error beat is registered and shows in the cycle after its input beat;
// the 14 header beats of a good frame follow its last header byte via the store's read register.
// Throughput: one link byte per cycle while the output does not stall, except that the last header
// byte of a good frame starts a replay of the header store, one byte per cycle while the output does
// not stall; input is held off for the whole replay.
// Reset: rst_n is synchronous and active low; parser state clears, max_length returns to 1600
// and station_prefix to zero. The header store has no reset and needs no clearing pass.
`include "parallel_link_rx_deframer_macros.svh"

module parallel_link_rx_deframer
  import pldf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // Link byte stream.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [7:0] rx_byte
  input  logic                   in_tuser,   // [0] timed_out
  // Deframed byte and status stream.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [31:0]            out_tdata,  // [7:0] out_byte, [10:8] status,
                                             // [26:11] frame_length, [31:27] zero
  output logic                   out_tuser,  // [0] is_data
  output logic                   out_tlast,  // last
  // Configuration writes.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Configuration registers; writes are taken at any time. The user must change
  // them only between frames; the block does not enforce it. The parser reads them directly.
  logic [15:0]           max_length_r;
  logic [CFG_DATA_W-1:0] station_prefix_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r     <= MAX_LENGTH_RESET;
      station_prefix_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MAX_LENGTH:     max_length_r     <= cfg_data[15:0];
        CFG_STATION_PREFIX: station_prefix_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The parser owns the frame state and the output register. Header bytes are
  // written into the store as they arrive; once the header is complete and the
  // length passes, the parser replays the store with one read in flight. Since
  // no header byte is written during the replay, a read never meets a write to
  // the same entry, and the first read comes in the cycle after the last write.
  mem_req_t   mem_req;
  logic [7:0] mem_rd_data;
  logic [7:0] out_byte;
  status_t    status;
  logic [15:0] frame_length;

  pldf_hdr_mem u_hdr_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_rd_data)
  );

  pldf_parser u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .rx_byte        (in_tdata),
    .timed_out      (in_tuser),
    .max_length     (max_length_r),
    .station_prefix (station_prefix_r),
    .mem_req        (mem_req),
    .mem_rd_data    (mem_rd_data),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_byte       (out_byte),
    .is_data        (out_tuser),
    .last           (out_tlast),
    .status         (status),
    .frame_length   (frame_length)
  );

  assign out_tdata = {5'b00000, frame_length, status, out_byte};

  // A beat is either a frame byte or the closing status beat, never both.
  `PLDF_ASSERT_IMP(a_last_is_status, out_tvalid, out_tlast == !out_tuser)
  // Frame byte beats carry a clean status field.
  `PLDF_ASSERT_IMP(a_data_status_ok, out_tvalid && out_tuser, out_tdata[10:8] == ST_OK)
  // A held result beat blocks new link bytes.
  `PLDF_ASSERT_IMP(a_stall_blocks_in, out_tvalid && !out_tready, !in_tready)
  // A timed-out link byte closes the frame with a timeout status on the next beat.
  `PLDF_ASSERT_NEXT(a_timeout_status, in_tvalid && in_tready && in_tuser,
                    out_tvalid && out_tlast && out_tdata[10:8] == ST_TIMEOUT)

endmodule
